FILE: rtl/core/iqm_pkg.sv
// iqm_pkg: shared constants for the image quality metrics block
`timescale 1ns / 1ps
package iqm_pkg;

  // default width of the sample counter
  localparam int COUNT_BITS_DEF = 24;

  // sample and result field widths
  localparam int SAMPLE_W = 8;
  localparam int MSE_W    = 24;
  localparam int PMSE_W   = 17;
  localparam int DB_W     = 16;

  // fixed-point scaling
  localparam int MSE_SHIFT  = 8;
  localparam int PMSE_SHIFT = 16;
  localparam int PEAK_SQ    = 65025;
  localparam int PEAK_SQ_W  = 16;
  localparam int LOG_FRAC   = 20;
  localparam int MANT_W     = 32;

  // 10*log10(2) in Q.16, and the rounding shift down to Q8.8
  localparam int DB_COEF   = 197283;
  localparam int DB_COEF_W = 18;
  localparam int DB_SHIFT  = 28;
  localparam int DB_NEG_LIMIT = 32768;
  localparam int DB_POS_LIMIT = 32767;

  // saturated decibel codes
  localparam logic signed [DB_W-1:0] DB_POS_MAX = 16'sh7FFF;
  localparam logic signed [DB_W-1:0] DB_NEG_MIN = 16'sh8000;

endpackage

FILE: rtl/core/image_quality_metrics.sv
// image_quality_metrics: streaming mse, pmse, snr and psnr over one image
//
// usage: the input channel takes one original/modified sample pair per transfer;
// in_last_sample marks the final pair of an image. sums, the sample count and
// the peak difference are accumulated at one transfer per cycle. on the last
// pair a snapshot is pushed into a two-entry queue and the sums clear, so the
// next image can stream in at once while the back end works.
// the back end runs one snapshot at a time: a restoring divider (one quotient
// bit per cycle, two divisions), then up to three log2 evaluations (normalize
// one bit per cycle, then 20 square/update steps, each a square state and an
// update state), then a multiply/round step per computed dB value.
// the input stalls only when two finished images wait in the queue.
// the result holds on the out_ ports until transferred; a stalled receiver
// stops the back end but not the front end until the queue fills.
// reset (rst_n low, synchronous) clears sums, the queue and the sequencer.
`timescale 1ns / 1ps
module image_quality_metrics #(
  parameter int COUNT_BITS = iqm_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [iqm_pkg::SAMPLE_W-1:0]    in_orig_sample,
  input  logic [iqm_pkg::SAMPLE_W-1:0]    in_mod_sample,
  input  logic                            in_last_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [iqm_pkg::MSE_W-1:0]       out_mse_q8,
  output logic [iqm_pkg::PMSE_W-1:0]      out_pmse_q16,
  output logic signed [iqm_pkg::DB_W-1:0] out_snr_db_q8,
  output logic signed [iqm_pkg::DB_W-1:0] out_psnr_db_q8,
  output logic [iqm_pkg::SAMPLE_W-1:0]    out_max_abs_diff,
  output logic                            out_images_identical,
  output logic                            out_signal_zero,
  output logic [COUNT_BITS:0]             out_sample_count
);

  localparam int SNAP_W = 2*(COUNT_BITS+16) + COUNT_BITS + 1 + iqm_pkg::SAMPLE_W;

  logic              snap_push;
  logic [SNAP_W-1:0] snap_data;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  logic [SNAP_W-1:0] q_data;

  // sample accumulation
  iqm_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_orig_sample(in_orig_sample),
    .in_mod_sample (in_mod_sample),
    .in_last_sample(in_last_sample),
    .q_full        (q_full),
    .snap_push     (snap_push),
    .snap_data     (snap_data)
  );

  // snapshot queue
  iqm_fifo #(.WIDTH(SNAP_W)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (snap_push),
    .push_data(snap_data),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_data (q_data)
  );

  // end-of-image arithmetic
  iqm_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_data              (q_data),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_mse_q8          (out_mse_q8),
    .out_pmse_q16        (out_pmse_q16),
    .out_snr_db_q8       (out_snr_db_q8),
    .out_psnr_db_q8      (out_psnr_db_q8),
    .out_max_abs_diff    (out_max_abs_diff),
    .out_images_identical(out_images_identical),
    .out_signal_zero     (out_signal_zero),
    .out_sample_count    (out_sample_count)
  );

endmodule

FILE: rtl/core/iqm_front.sv
// iqm_front: per-sample accumulation of square sums, count and peak difference
`timescale 1ns / 1ps
module iqm_front #(
  parameter int COUNT_BITS = iqm_pkg::COUNT_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [iqm_pkg::SAMPLE_W-1:0]           in_orig_sample,
  input  logic [iqm_pkg::SAMPLE_W-1:0]           in_mod_sample,
  input  logic                                   in_last_sample,
  input  logic                                   q_full,
  output logic                                   snap_push,
  output logic [2*(COUNT_BITS+16)+COUNT_BITS+1+iqm_pkg::SAMPLE_W-1:0] snap_data
);

  localparam int SW  = COUNT_BITS + 16;
  localparam int NCW = COUNT_BITS + 1;
  localparam int XW  = iqm_pkg::SAMPLE_W;

  logic [SW-1:0]  s_sum_r, s_sum_nxt;
  logic [SW-1:0]  e_sum_r, e_sum_nxt;
  logic [NCW-1:0] cnt_r, cnt_nxt;
  logic [XW-1:0]  md_r, md_nxt;
  logic [XW-1:0]  diff;
  logic [2*XW-1:0] sq_o, sq_d;
  logic           room;
  logic           xfer;

  // a transfer is taken whenever the snapshot queue has space
  assign in_ready = !q_full;
  assign xfer     = in_valid && in_ready;

  // running values including the current sample
  always_comb begin
    room = !cnt_r[COUNT_BITS];
    diff = (in_orig_sample >= in_mod_sample) ? (in_orig_sample - in_mod_sample)
                                             : (in_mod_sample - in_orig_sample);
    sq_o = (2*XW)'(in_orig_sample) * (2*XW)'(in_orig_sample);
    sq_d = (2*XW)'(diff) * (2*XW)'(diff);
    s_sum_nxt = s_sum_r + (room ? SW'(sq_o) : SW'(0));
    e_sum_nxt = e_sum_r + (room ? SW'(sq_d) : SW'(0));
    cnt_nxt   = cnt_r + (room ? NCW'(1) : NCW'(0));
    md_nxt    = (room && (diff > md_r)) ? diff : md_r;
  end

  // snapshot handed to the back end on the last sample
  assign snap_push = xfer && in_last_sample;
  assign snap_data = {s_sum_nxt, e_sum_nxt, cnt_nxt, md_nxt};

  // accumulators, cleared after each image
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_sum_r <= '0;
      e_sum_r <= '0;
      cnt_r   <= '0;
      md_r    <= '0;
    end else if (xfer) begin
      if (in_last_sample) begin
        s_sum_r <= '0;
        e_sum_r <= '0;
        cnt_r   <= '0;
        md_r    <= '0;
      end else begin
        s_sum_r <= s_sum_nxt;
        e_sum_r <= e_sum_nxt;
        cnt_r   <= cnt_nxt;
        md_r    <= md_nxt;
      end
    end
  end

endmodule

FILE: rtl/core/iqm_fifo.sv
// iqm_fifo: two-entry queue of image snapshots between front and back
`timescale 1ns / 1ps
module iqm_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r;
  logic             rp_r;
  logic [1:0]       cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign valid    = (cnt_r != 2'd0);
  assign pop_data = mem_r[rp_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("snapshot queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid)
    else $error("snapshot queue read while empty");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("snapshot queue count did not advance");

endmodule

FILE: rtl/core/iqm_back.sv
// iqm_back: end-of-image divisions, log2 iterations and decibel results
`timescale 1ns / 1ps
module iqm_back #(
  parameter int COUNT_BITS = iqm_pkg::COUNT_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   q_valid,
  input  logic [2*(COUNT_BITS+16)+COUNT_BITS+1+iqm_pkg::SAMPLE_W-1:0] q_data,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [iqm_pkg::MSE_W-1:0]              out_mse_q8,
  output logic [iqm_pkg::PMSE_W-1:0]             out_pmse_q16,
  output logic signed [iqm_pkg::DB_W-1:0]        out_snr_db_q8,
  output logic signed [iqm_pkg::DB_W-1:0]        out_psnr_db_q8,
  output logic [iqm_pkg::SAMPLE_W-1:0]           out_max_abs_diff,
  output logic                                   out_images_identical,
  output logic                                   out_signal_zero,
  output logic [COUNT_BITS:0]                    out_sample_count
);

  localparam int SW   = COUNT_BITS + 16;
  localparam int NCW  = COUNT_BITS + 1;
  localparam int XW   = iqm_pkg::SAMPLE_W;
  localparam int AW   = COUNT_BITS + 17;
  localparam int DW   = COUNT_BITS + 32;
  localparam int DCW  = $clog2(DW);
  localparam int MW   = iqm_pkg::MANT_W;
  localparam int NW   = AW + MW;
  localparam int EW   = $clog2(NW);
  localparam int LF   = iqm_pkg::LOG_FRAC;
  localparam int LQW  = EW + LF;
  localparam int PW   = LQW + iqm_pkg::DB_COEF_W;
  localparam int ITW  = $clog2(LF);
  localparam int DBW  = iqm_pkg::DB_W;
  localparam logic [PW:0] RND = (PW+1)'(1) << (iqm_pkg::DB_SHIFT - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_AMUL, ST_DIV, ST_LNORM, ST_LSQ, ST_LUPD, ST_DBMUL, ST_DBRND, ST_OUT
  } state_t;

  typedef enum logic [1:0] {LS_E, LS_A, LS_S} lsel_t;

  state_t          state_r;
  lsel_t           lsel_r;
  logic [SW-1:0]   s_r, e_r;
  logic [NCW-1:0]  n_r;
  logic [AW-1:0]   a_r;
  logic            ident_r, szero_r;
  logic [DW-1:0]   dq_r;
  logic [AW-1:0]   rem_r;
  logic [DCW-1:0]  dcnt_r;
  logic            dsel_r;
  logic [NW-1:0]   nv_r;
  logic [EW-1:0]   k_r;
  logic [EW-1:0]   lexp_r;
  logic [MW-1:0]   m_r;
  logic [2*MW-1:0] p_r;
  logic [LF-1:0]   lbits_r;
  logic [ITW-1:0]  it_r;
  logic [LQW-1:0]  l_s_r, l_e_r, l_a_r;
  logic            dbsel_r;
  logic            neg_r;
  logic [PW-1:0]   prod_r;

  logic [AW-1:0]   div_d;
  logic [AW:0]     rs;
  logic            ge;
  logic [AW-1:0]   rem_nxt;
  logic [DW-1:0]   dq_nxt;
  logic [MW:0]     sq_t;
  logic            lbit;
  logic [MW-1:0]   m_nxt;
  logic [LF-1:0]   lbits_nxt;
  logic [LQW-1:0]  lq;
  logic signed [LQW:0] dlog;
  logic [LQW-1:0]  dmag;
  logic [PW:0]     qv;
  logic signed [DBW-1:0] dbv;

  // restoring divider step
  always_comb begin
    div_d   = dsel_r ? a_r : AW'(n_r);
    rs      = {rem_r, dq_r[DW-1]};
    ge      = (rs >= {1'b0, div_d});
    rem_nxt = ge ? AW'(rs - {1'b0, div_d}) : AW'(rs);
    dq_nxt  = {dq_r[DW-2:0], ge};
  end

  // log2 fraction step from the registered square
  always_comb begin
    sq_t      = (MW+1)'(p_r >> (MW - 1));
    lbit      = sq_t[MW];
    m_nxt     = lbit ? sq_t[MW:1] : sq_t[MW-1:0];
    lbits_nxt = {lbits_r[LF-2:0], lbit};
    lq        = {lexp_r, lbits_nxt};
  end

  // decibel difference and rounding
  always_comb begin
    dlog = $signed({1'b0, (dbsel_r ? l_s_r : l_a_r)}) - $signed({1'b0, l_e_r});
    dmag = dlog[LQW] ? LQW'(-dlog) : LQW'(dlog);
    qv   = ((PW+1)'(prod_r) + RND) >> iqm_pkg::DB_SHIFT;
    if (neg_r) begin
      dbv = (qv >= (PW+1)'(iqm_pkg::DB_NEG_LIMIT)) ? iqm_pkg::DB_NEG_MIN
                                                  : -$signed(DBW'(qv));
    end else begin
      dbv = (qv > (PW+1)'(iqm_pkg::DB_POS_LIMIT)) ? iqm_pkg::DB_POS_MAX
                                                 : $signed(DBW'(qv));
    end
  end

  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign out_valid = (state_r == ST_OUT);

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            {s_r, e_r, n_r, out_max_abs_diff} <= q_data;
            ident_r <= (q_data[NCW+XW +: SW] == '0);
            szero_r <= (q_data[SW+NCW+XW +: SW] == '0);
            state_r <= ST_AMUL;
          end
        end
        ST_AMUL: begin
          a_r     <= AW'(n_r) * AW'(iqm_pkg::PEAK_SQ);
          dq_r    <= DW'({e_r, {iqm_pkg::MSE_SHIFT{1'b0}}});
          rem_r   <= '0;
          dcnt_r  <= '0;
          dsel_r  <= 1'b0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          rem_r  <= rem_nxt;
          dq_r   <= dq_nxt;
          dcnt_r <= dcnt_r + DCW'(1);
          if (dcnt_r == DCW'(DW - 1)) begin
            rem_r  <= '0;
            dcnt_r <= '0;
            if (!dsel_r) begin
              out_mse_q8 <= dq_nxt[iqm_pkg::MSE_W-1:0];
              dq_r       <= DW'({e_r, {iqm_pkg::PMSE_SHIFT{1'b0}}});
              dsel_r     <= 1'b1;
            end else begin
              out_pmse_q16 <= dq_nxt[iqm_pkg::PMSE_W-1:0];
              if (ident_r) begin
                out_snr_db_q8  <= iqm_pkg::DB_POS_MAX;
                out_psnr_db_q8 <= iqm_pkg::DB_POS_MAX;
                state_r        <= ST_OUT;
              end else begin
                lsel_r  <= LS_E;
                nv_r    <= NW'(e_r);
                k_r     <= '0;
                state_r <= ST_LNORM;
              end
            end
          end
        end
        ST_LNORM: begin
          if (nv_r[NW-1]) begin
            m_r     <= nv_r[NW-1 -: MW];
            lexp_r  <= EW'(NW - 1) - k_r;
            lbits_r <= '0;
            it_r    <= '0;
            state_r <= ST_LSQ;
          end else begin
            nv_r <= nv_r << 1;
            k_r  <= k_r + EW'(1);
          end
        end
        ST_LSQ: begin
          p_r     <= (2*MW)'(m_r) * (2*MW)'(m_r);
          state_r <= ST_LUPD;
        end
        ST_LUPD: begin
          m_r     <= m_nxt;
          lbits_r <= lbits_nxt;
          it_r    <= it_r + ITW'(1);
          state_r <= ST_LSQ;
          if (it_r == ITW'(LF - 1)) begin
            k_r <= '0;
            unique case (lsel_r)
              LS_E: begin
                l_e_r   <= lq;
                lsel_r  <= LS_A;
                nv_r    <= NW'(a_r);
                state_r <= ST_LNORM;
              end
              LS_A: begin
                l_a_r <= lq;
                if (szero_r) begin
                  dbsel_r <= 1'b0;
                  state_r <= ST_DBMUL;
                end else begin
                  lsel_r  <= LS_S;
                  nv_r    <= NW'(s_r);
                  state_r <= ST_LNORM;
                end
              end
              LS_S: begin
                l_s_r   <= lq;
                dbsel_r <= 1'b0;
                state_r <= ST_DBMUL;
              end
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        ST_DBMUL: begin
          neg_r   <= dlog[LQW];
          prod_r  <= PW'(dmag) * PW'(iqm_pkg::DB_COEF);
          state_r <= ST_DBRND;
        end
        ST_DBRND: begin
          if (!dbsel_r) begin
            out_psnr_db_q8 <= dbv;
            if (szero_r) begin
              out_snr_db_q8 <= iqm_pkg::DB_NEG_MIN;
              state_r       <= ST_OUT;
            end else begin
              dbsel_r <= 1'b1;
              state_r <= ST_DBMUL;
            end
          end else begin
            out_snr_db_q8 <= dbv;
            state_r       <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_images_identical = ident_r;
  assign out_signal_zero      = szero_r;
  assign out_sample_count     = n_r;

  a_ident_db: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_images_identical) |->
      (out_snr_db_q8 == iqm_pkg::DB_POS_MAX && out_psnr_db_q8 == iqm_pkg::DB_POS_MAX))
    else $error("identical images without saturated decibel results");

  a_szero_snr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_signal_zero && !out_images_identical) |->
      (out_snr_db_q8 == iqm_pkg::DB_NEG_MIN))
    else $error("zero signal without minimum snr");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample_count != '0))
    else $error("result with zero sample count");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_AMUL))
    else $error("snapshot taken without starting the sequence");

endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking testbench for the image quality metrics block
`timescale 1ns / 1ps
module tb_top;

  localparam int CNT_W        = iqm_pkg::COUNT_BITS_DEF;
  localparam int LATENCY      = 2 * (CNT_W + 32) + 3 * (CNT_W + 90) + 10;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int RANDOM_ITEMS = 700;
  localparam int LONG_HOLD    = 3000;

  typedef struct packed {
    logic [iqm_pkg::MSE_W-1:0]       mse;
    logic [iqm_pkg::PMSE_W-1:0]      pmse;
    logic signed [iqm_pkg::DB_W-1:0] snr;
    logic signed [iqm_pkg::DB_W-1:0] psnr;
    logic [iqm_pkg::SAMPLE_W-1:0]    max_diff;
    logic                            ident;
    logic                            szero;
    logic [CNT_W:0]                  count;
  } metrics_t;

  typedef struct {
    logic [iqm_pkg::SAMPLE_W-1:0] orig;
    logic [iqm_pkg::SAMPLE_W-1:0] modv;
    logic                         last;
    logic                         fixed;
    metrics_t                     res;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [iqm_pkg::SAMPLE_W-1:0] in_orig_sample = '0;
  logic [iqm_pkg::SAMPLE_W-1:0] in_mod_sample = '0;
  logic in_last_sample = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [iqm_pkg::MSE_W-1:0] out_mse_q8;
  logic [iqm_pkg::PMSE_W-1:0] out_pmse_q16;
  logic signed [iqm_pkg::DB_W-1:0] out_snr_db_q8;
  logic signed [iqm_pkg::DB_W-1:0] out_psnr_db_q8;
  logic [iqm_pkg::SAMPLE_W-1:0] out_max_abs_diff;
  logic out_images_identical;
  logic out_signal_zero;
  logic [CNT_W:0] out_sample_count;

  // image accumulators of the predictor
  longint unsigned sig_sum, err_sum, peak_diff, pixel_count;

  metrics_t   pending_metrics[$];
  pixel_row_t pixel_table[$];
  int errors = 0;
  int images_done = 0;
  int pixels_sent = 0;
  int cycles = 0;

  always #2ns clk = ~clk;

  image_quality_metrics #(.COUNT_BITS(CNT_W)) u_top (.*);

  // log2 in unsigned Q.20 by repeated squaring of the normalized mantissa
  function automatic longint unsigned log2_q20(longint unsigned v);
    int unsigned e;
    longint unsigned t, m, r;
    e = 0;
    t = v;
    while (t > 1) begin
      t = t >> 1;
      e++;
    end
    m = (e >= 31) ? (v >> (e - 31)) : (v << (31 - e));
    r = longint'(e) << iqm_pkg::LOG_FRAC;
    for (int i = iqm_pkg::LOG_FRAC - 1; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= (64'd1 << 32)) begin
        r |= 64'd1 << i;
        m = m >> 1;
      end
    end
    return r;
  endfunction

  // 10*log10(a/b) in Q8.8, rounded half away from zero and saturated
  function automatic logic signed [iqm_pkg::DB_W-1:0] db_ratio(longint unsigned a,
                                                               longint unsigned b);
    longint d;
    longint unsigned mag, q;
    d = longint'(log2_q20(a)) - longint'(log2_q20(b));
    mag = (d < 0) ? longint'(-d) : longint'(d);
    q = (mag * iqm_pkg::DB_COEF + (64'd1 << 27)) >> iqm_pkg::DB_SHIFT;
    if (q > iqm_pkg::DB_NEG_LIMIT) q = iqm_pkg::DB_NEG_LIMIT;
    if (d < 0) return iqm_pkg::DB_W'(-longint'(q));
    if (q > iqm_pkg::DB_POS_LIMIT) q = iqm_pkg::DB_POS_LIMIT;
    return iqm_pkg::DB_W'(q);
  endfunction

  // accumulate one transferred pixel pair; returns 1 with metrics on the last one
  function automatic bit add_pixel(logic [7:0] o, logic [7:0] mv, logic last,
                                   output metrics_t res);
    longint unsigned diff;
    res = '0;
    if (pixel_count < (64'd1 << CNT_W)) begin
      diff = (o >= mv) ? o - mv : mv - o;
      sig_sum += o * o;
      err_sum += diff * diff;
      if (diff > peak_diff) peak_diff = diff;
      pixel_count++;
    end
    if (!last) return 0;
    res.ident = (err_sum == 0);
    res.szero = (sig_sum == 0);
    if (res.ident) begin
      res.snr = iqm_pkg::DB_POS_MAX;
      res.psnr = iqm_pkg::DB_POS_MAX;
    end else begin
      res.snr = res.szero ? iqm_pkg::DB_NEG_MIN : db_ratio(sig_sum, err_sum);
      res.psnr = db_ratio(iqm_pkg::PEAK_SQ * pixel_count, err_sum);
    end
    res.mse = iqm_pkg::MSE_W'((err_sum << iqm_pkg::MSE_SHIFT) / pixel_count);
    res.pmse = iqm_pkg::PMSE_W'((err_sum << iqm_pkg::PMSE_SHIFT) /
                                (pixel_count * iqm_pkg::PEAK_SQ));
    res.max_diff = iqm_pkg::SAMPLE_W'(peak_diff);
    res.count = (CNT_W+1)'(pixel_count);
    sig_sum = 0;
    err_sum = 0;
    peak_diff = 0;
    pixel_count = 0;
    return 1;
  endfunction

  // drive one pixel pair and wait for its transfer
  task automatic send_pixel(logic [7:0] o, logic [7:0] mv, logic last, bit fixed,
                            metrics_t fixed_res, int gap);
    metrics_t res;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_orig_sample <= o;
    in_mod_sample <= mv;
    in_last_sample <= last;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
    if (add_pixel(o, mv, last, res)) pending_metrics.push_back(fixed ? fixed_res : res);
  endtask

  function automatic void add_row(logic [7:0] o, logic [7:0] mv, logic last);
    pixel_row_t r;
    r.orig = o;
    r.modv = mv;
    r.last = last;
    r.fixed = 1'b0;
    r.res = '0;
    pixel_table.push_back(r);
  endfunction

  function automatic void add_fixed(logic [7:0] o, logic [7:0] mv, metrics_t res);
    pixel_row_t r;
    r.orig = o;
    r.modv = mv;
    r.last = 1'b1;
    r.fixed = 1'b1;
    r.res = res;
    pixel_table.push_back(r);
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               pending_metrics.size());
      $display("Verification failed");
      $finish;
    end
  end

  // result checking on each output transfer
  always @(posedge clk) begin
    metrics_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_mse_q8, out_pmse_q16, out_snr_db_q8, out_psnr_db_q8, out_max_abs_diff,
              out_images_identical, out_signal_zero, out_sample_count};
      if (pending_metrics.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer: %p", got);
      end else begin
        want = pending_metrics.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("image %0d mismatch", images_done);
            $display("  expected mse %0d pmse %0d snr %0d psnr %0d max %0d id %b sz %b n %0d",
                     want.mse, want.pmse, want.snr, want.psnr, want.max_diff,
                     want.ident, want.szero, want.count);
            $display("  actual   mse %0d pmse %0d snr %0d psnr %0d max %0d id %b sz %b n %0d",
                     got.mse, got.pmse, got.snr, got.psnr, got.max_diff,
                     got.ident, got.szero, got.count);
          end
        end
      end
      images_done++;
    end
  end

  // result receiver: random stalls, bursts without stalls, one long hold-off
  initial begin
    int gap;
    int taken;
    taken = 0;
    @(posedge rst_n);
    forever begin
      if (taken == 20) gap = LONG_HOLD;
      else if ((taken / 15) % 3 == 2) gap = 0;
      else gap = $urandom_range(0, 9);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // stimulus
  initial begin
    int gap, len, mode, img, items;
    logic [7:0] o, mv;
    sig_sum = 0;
    err_sum = 0;
    peak_diff = 0;
    pixel_count = 0;

    // single-pixel images with results readable by hand
    add_fixed(8'd100, 8'd100,
              '{0, 0, iqm_pkg::DB_POS_MAX, iqm_pkg::DB_POS_MAX, 0, 1, 1'b0, 1});
    add_fixed(8'd0, 8'd0,
              '{0, 0, iqm_pkg::DB_POS_MAX, iqm_pkg::DB_POS_MAX, 0, 1, 1'b1, 1});
    add_fixed(8'd0, 8'd255, '{16646400, 65536, iqm_pkg::DB_NEG_MIN, 0, 255, 0, 1'b1, 1});
    add_fixed(8'd255, 8'd0, '{16646400, 65536, 0, 0, 255, 0, 1'b0, 1});
    // multi-pixel and single-pixel images with extremes
    add_row(8'd255, 8'd255, 1'b0);
    add_row(8'd0, 8'd255, 1'b0);
    add_row(8'd128, 8'd127, 1'b1);
    add_row(8'd1, 8'd0, 1'b0);
    add_row(8'd2, 8'd3, 1'b0);
    add_row(8'd85, 8'd170, 1'b0);
    add_row(8'd170, 8'd85, 1'b1);
    add_row(8'd254, 8'd1, 1'b1);
    // zero signal with small error over two pixels
    add_row(8'd0, 8'd1, 1'b0);
    add_row(8'd0, 8'd0, 1'b1);
    // identical image with nonzero signal
    add_row(8'd255, 8'd255, 1'b0);
    add_row(8'd17, 8'd17, 1'b1);
    // large signal, tiny error
    add_row(8'd255, 8'd255, 1'b0);
    add_row(8'd255, 8'd254, 1'b1);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (pixel_table[i])
      send_pixel(pixel_table[i].orig, pixel_table[i].modv, pixel_table[i].last,
                 pixel_table[i].fixed, pixel_table[i].res, $urandom_range(0, 3));

    // random images, mostly short, a few long
    items = 0;
    img = 0;
    while (items < RANDOM_ITEMS) begin
      if (img == 30) begin
        in_valid <= 1'b0;
        wait (pending_metrics.size() == 0);
      end
      case ($urandom_range(0, 19))
        0:       len = $urandom_range(100, 300);
        1, 2:    len = $urandom_range(20, 60);
        default: len = $urandom_range(1, 8);
      endcase
      mode = $urandom_range(0, 9);
      for (int k = 0; k < len; k++) begin
        o = 8'($urandom_range(0, 255));
        case (mode)
          0:       mv = o;
          1: begin
            o = 8'd0;
            mv = 8'($urandom_range(0, 255));
          end
          2, 3:    mv = 8'(o + $urandom_range(0, 4) - 2);
          4:       mv = ~o;
          default: mv = 8'($urandom_range(0, 255));
        endcase
        gap = ((items / 50) % 3 == 1) ? 0 : $urandom_range(0, 9);
        send_pixel(o, mv, k == len - 1, 1'b0, '0, gap);
        items++;
      end
      img++;
    end
    in_valid <= 1'b0;

    wait (pending_metrics.size() == 0);
    repeat (LATENCY + 100) @(posedge clk);
    $display("covered %0d pixel transfers over %0d images in %0d cycles", pixels_sent,
             images_done, cycles);
    $display("directed extremes, zero-error and zero-signal images, long receiver hold-off");
    if (errors == 0 && pending_metrics.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_metrics.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
